// ----- rtl/sgl_pkg.sv -----
// Shared types and constants for the scatter-gather list walker.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package sgl_pkg;

	// action codes carried in s_tuser
	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_SEEK = 2'd1;
	localparam logic [1:0] ACT_NEXT = 2'd2;

	localparam int ACT_W   = 2;
	localparam int CNT_W   = 6;
	localparam int SLOT_W  = 5;
	localparam int ADDR_W  = 64;
	localparam int LEN_W   = 32;

	// input word layout, lowest bit up
	localparam int IN_DATA_W = 168;
	localparam int IN_IDX_LO = 0;
	localparam int IN_BAS_LO = IN_IDX_LO + SLOT_W;
	localparam int IN_STA_LO = IN_BAS_LO + ADDR_W;
	localparam int IN_LEN_LO = IN_STA_LO + LEN_W;
	localparam int IN_SEK_LO = IN_LEN_LO + LEN_W;

	// output word layout: address then length
	localparam int OUT_DATA_W = ADDR_W + LEN_W;

	// one table entry: base already offset by start
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] bs;
	} entry_t;

	// seek unit status toward the top level
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [LEN_W-1:0] bytes_left;
	} seek_stat_t;

endpackage

// ----- rtl/sgl_seg_mem.sv -----
// Segment table memory: one write port, one read port with registered read data.
// Uses sgl_pkg::entry_t for the stored word.
`timescale 1ns / 1ps

module sgl_seg_mem #(
	parameter int DEPTH = 32,
	parameter int IDX_W = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  sgl_pkg::entry_t      wdata,
	input  logic                 re,
	input  logic [IDX_W-1:0]     raddr,
	output sgl_pkg::entry_t      rdata
);

	sgl_pkg::entry_t mem_q [DEPTH];
	sgl_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sgl_seek.sv -----
// Seek sequencer: walks the segment table one read per cycle, summing lengths.
// Drives the table read port while busy; uses sgl_pkg::seek_stat_t.
`timescale 1ns / 1ps

module sgl_seek #(
	parameter int IDX_W = 5,
	parameter int CUR_W = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [sgl_pkg::LEN_W-1:0] target,
	input  logic [CUR_W-1:0]          count,
	input  logic [sgl_pkg::LEN_W-1:0] rd_len,
	output logic                      rd_en,
	output logic [IDX_W-1:0]          rd_addr,
	output logic [CUR_W-1:0]          cursor,
	output sgl_pkg::seek_stat_t       stat
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_WALK = 1'b1;

	logic                      state_q;
	logic [CUR_W-1:0]          iss_q;
	logic [CUR_W-1:0]          chk_q;
	logic [sgl_pkg::LEN_W-1:0] sum_q;
	logic [sgl_pkg::LEN_W-1:0] tgt_q;
	logic                      rvld_s1;

	logic [sgl_pkg::LEN_W-1:0] sum_nx;
	logic                      hit;
	logic                      last;
	logic                      done;

	assign sum_nx = sum_q + rd_len;
	assign hit    = sum_nx > tgt_q;
	assign last   = (chk_q + 1'b1) == count;

	assign rd_en   = (state_q == S_WALK) && (iss_q < count);
	assign rd_addr = iss_q[IDX_W-1:0];

	always_comb begin
		done            = 1'b0;
		cursor          = count;
		stat.busy       = (state_q == S_WALK);
		stat.bytes_left = sum_q - tgt_q;
		if (state_q == S_WALK) begin
			if (chk_q == count) begin
				done = 1'b1;
			end else if (rvld_s1 && (hit || last)) begin
				done            = 1'b1;
				cursor          = hit ? chk_q : count;
				stat.bytes_left = sum_nx - tgt_q;
			end
		end
		stat.done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iss_q   <= '0;
			chk_q   <= '0;
			sum_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					rvld_s1 <= 1'b0;
					if (start) begin
						state_q <= S_WALK;
						iss_q   <= '0;
						chk_q   <= '0;
						sum_q   <= '0;
					end
				end
				S_WALK: begin
					rvld_s1 <= rd_en;
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (done) begin
						state_q <= S_IDLE;
					end else if (rvld_s1) begin
						sum_q <= sum_nx;
						chk_q <= chk_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// target needs no reset
	always_ff @(posedge clk) begin
		if (start && (state_q == S_IDLE)) begin
			tgt_q <= target;
		end
	end

endmodule

// ----- rtl/scatter_gather_list_walker.sv -----
// Top level of the scatter-gather list walker: cursor, fetch pipeline, output register.
// Depends on sgl_pkg, sgl_seg_mem and sgl_seek.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one word per item. s_tuser holds the action (load, seek,
//   next); s_tdata holds the entry fields and the seek offset. Loads and seeks
//   return nothing; a next word returns one address/length pair on m_*.
//   Config channel (cfg_*): writes segment_count; always ready, and is to be
//   written only while the block is idle.
//   Path: a next word is registered in the read stage, with the table read, and
//   then in the output register before its result shows on m_*.
//   Throughput: next, load and undefined words do not hold the input, so next
//   words stream one per cycle while the output side is not stalled. A seek
//   holds s_tready low while its walk runs: the single table read port walks
//   one entry per cycle through the running sum, up to the effective segment
//   count, and the walk stops early at the first segment that passes the offset.
//   Reset (arst_n low): cursor, bytes left, segment_count and all valid flags
//   clear. The table is not cleared; entries read before a load are garbage.
//   Stall: when m_tready is low the result holds in the output register and
//   one more next word may sit in the read stage; s_tready then drops.

module scatter_gather_list_walker #(
	parameter int MAX_SEGMENTS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input stream handshake
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [4:0] entry_index, [68:5] entry_base, [100:69] entry_start,
	// [132:101] entry_length, [164:133] seek_offset, [167:165] zero
	input  logic [sgl_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] action
	input  logic [sgl_pkg::ACT_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [63:0] seg_address, [95:64] seg_length
	output logic [sgl_pkg::OUT_DATA_W-1:0] m_tdata,
	// [0] exhausted
	output logic                           m_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	// [5:0] segment_count
	input  logic [sgl_pkg::CNT_W-1:0]      cfg_data
);

	localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CUR_W = $clog2(MAX_SEGMENTS + 1);

	// unpack input word
	logic [sgl_pkg::SLOT_W-1:0] entry_index;
	logic [sgl_pkg::ADDR_W-1:0] entry_base;
	logic [sgl_pkg::LEN_W-1:0]  entry_start;
	logic [sgl_pkg::LEN_W-1:0]  entry_length;
	logic [sgl_pkg::LEN_W-1:0]  seek_offset;

	assign entry_index  = s_tdata[sgl_pkg::IN_IDX_LO +: sgl_pkg::SLOT_W];
	assign entry_base   = s_tdata[sgl_pkg::IN_BAS_LO +: sgl_pkg::ADDR_W];
	assign entry_start  = s_tdata[sgl_pkg::IN_STA_LO +: sgl_pkg::LEN_W];
	assign entry_length = s_tdata[sgl_pkg::IN_LEN_LO +: sgl_pkg::LEN_W];
	assign seek_offset  = s_tdata[sgl_pkg::IN_SEK_LO +: sgl_pkg::LEN_W];

	logic [sgl_pkg::CNT_W-1:0]  cnt_q;
	logic [CUR_W-1:0]           cursor_q;
	logic [sgl_pkg::LEN_W-1:0]  left_q;
	logic [CUR_W-1:0]           n_eff;

	// read stage of a next word
	logic                       s1_vld;
	logic                       s1_exh;
	logic [sgl_pkg::LEN_W-1:0]  s1_left;

	// output register
	logic                       out_vld_q;
	logic [sgl_pkg::ADDR_W-1:0] out_addr_q;
	logic [sgl_pkg::LEN_W-1:0]  out_len_q;
	logic                       out_exh_q;

	logic                       adv;
	logic                       acc;
	logic                       is_load;
	logic                       is_seek;
	logic                       is_next;
	logic                       exh_now;

	sgl_pkg::seek_stat_t        seek_stat;
	logic                       seek_rd_en;
	logic [IDX_W-1:0]           seek_rd_addr;
	logic [CUR_W-1:0]           seek_cursor;

	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	sgl_pkg::entry_t            mem_wdata;
	logic                       mem_re;
	logic [IDX_W-1:0]           mem_raddr;
	sgl_pkg::entry_t            mem_rdata;

	// clamp count to table capacity
	assign n_eff = (32'(cnt_q) > MAX_SEGMENTS) ? CUR_W'(MAX_SEGMENTS) : CUR_W'(cnt_q);

	// output side frees up when empty or taken this cycle
	assign adv      = !out_vld_q || m_tready;
	assign s_tready = !seek_stat.busy && (!s1_vld || adv);
	assign acc      = s_tvalid && s_tready;
	assign exh_now  = cursor_q >= n_eff;

	always_comb begin
		is_load = 1'b0;
		is_seek = 1'b0;
		is_next = 1'b0;
		unique case (s_tuser)
			sgl_pkg::ACT_LOAD: is_load = 1'b1;
			sgl_pkg::ACT_SEEK: is_seek = 1'b1;
			sgl_pkg::ACT_NEXT: is_next = 1'b1;
			default: ;
		endcase
	end

	// load: drop slots beyond capacity, fold start into base at write time
	assign mem_we          = acc && is_load && (32'(entry_index) < MAX_SEGMENTS);
	assign mem_waddr       = IDX_W'(entry_index);
	assign mem_wdata.bs    = entry_base + sgl_pkg::ADDR_W'(entry_start);
	assign mem_wdata.len   = entry_length;

	// the read port belongs to the seek walk while it runs, else to next words
	assign mem_re    = seek_stat.busy ? seek_rd_en : (acc && is_next && !exh_now);
	assign mem_raddr = seek_stat.busy ? seek_rd_addr : cursor_q[IDX_W-1:0];

	sgl_seg_mem #(
		.DEPTH (MAX_SEGMENTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sgl_seek #(
		.IDX_W (IDX_W),
		.CUR_W (CUR_W)
	) u_seek (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (acc && is_seek),
		.target  (seek_offset),
		.count   (n_eff),
		.rd_len  (mem_rdata.len),
		.rd_en   (seek_rd_en),
		.rd_addr (seek_rd_addr),
		.cursor  (seek_cursor),
		.stat    (seek_stat)
	);

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_valid) begin
			cnt_q <= cfg_data;
		end
	end

	// cursor: advance on each next word in range, reload at end of a seek
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			left_q   <= '0;
		end else if (seek_stat.done) begin
			cursor_q <= seek_cursor;
			left_q   <= seek_stat.bytes_left;
		end else if (acc && is_next && !exh_now) begin
			cursor_q <= cursor_q + 1'b1;
			left_q   <= '0;
		end
	end

	// read stage: table data arrives from the memory register this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (!s1_vld || adv) begin
			s1_vld <= acc && is_next;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_next) begin
			s1_exh  <= exh_now;
			s1_left <= left_q;
		end
	end

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= s1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_vld) begin
			out_exh_q <= s1_exh;
			if (s1_exh) begin
				out_addr_q <= '0;
				out_len_q  <= '0;
			end else if (s1_left != '0) begin
				// tail of a partly consumed segment
				out_addr_q <= mem_rdata.bs + sgl_pkg::ADDR_W'(mem_rdata.len)
				              - sgl_pkg::ADDR_W'(s1_left);
				out_len_q  <= s1_left;
			end else begin
				out_addr_q <= mem_rdata.bs;
				out_len_q  <= mem_rdata.len;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_len_q, out_addr_q};
	assign m_tuser  = out_exh_q;

endmodule

// ----- rtl/sgl_checker.sv -----
// Port-level checker for the scatter-gather list walker, bound to the top level.
// Depends on sgl_pkg for the action codes and word widths.
`timescale 1ns / 1ps

module sgl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [sgl_pkg::ACT_W-1:0]      s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [sgl_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	// exhausted word carries zero address and length
	a_exh_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("exhausted word with nonzero data");

	// seek walk blocks the input side on the following cycle
	a_seek_lock: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == sgl_pkg::ACT_SEEK) |=> !s_tready)
		else $error("input accepted during seek walk");

endmodule

bind scatter_gather_list_walker sgl_checker u_sgl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
